FILE: hdl/i2c_register_access_master_core_assert.svh
// ----------------------------------------------------------------------------
// I2C register access master - assertion macros
// Shared concurrent assertion forms used by the checker of the master core.
// ----------------------------------------------------------------------------
`ifndef I2C_REGISTER_ACCESS_MASTER_CORE_ASSERT_SVH
`define I2C_REGISTER_ACCESS_MASTER_CORE_ASSERT_SVH

// Property checked on every clock edge outside of reset.
`define I2CRAM_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset cycles included.
`define I2CRAM_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: hdl/i2cram_pkg.sv
// ----------------------------------------------------------------------------
// I2C register access master - package
// Payload types, command and operation codes, and the transaction sequences.
// ----------------------------------------------------------------------------
package i2cram_pkg;

    // Command codes carried in the func field.
    typedef enum logic [1:0] {
        FUNC_TICK           = 2'd0,
        FUNC_WRITE_READBACK = 2'd1,
        FUNC_READ_REG       = 2'd2,
        FUNC_READ_MEAS      = 2'd3
    } t_func;

    // Bus operations that make up a transaction.
    typedef enum logic [2:0] {
        OP_START   = 3'd0,
        OP_STOP    = 3'd1,
        OP_ADDR_W  = 3'd2,
        OP_REG     = 3'd3,
        OP_VAL     = 3'd4,
        OP_ADDR_R  = 3'd5,
        OP_RD_ACK  = 3'd6,
        OP_RD_NACK = 3'd7
    } t_op;

    // Phases of one bit slot or one start or stop condition.
    localparam logic [1:0] PH_SET  = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;

    // Slot index of the acknowledge bit after eight data bits.
    localparam logic [3:0] ACK_SLOT = 4'd8;

    localparam int DEV_ADDR_W = 7;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic       sda_in;
    } t_cmd_item;

    typedef struct packed {
        logic        scl_pull_low;
        logic        sda_pull_low;
        logic        busy_res;
        logic        done_res;
        logic [15:0] read_result;
        logic        nack_seen;
    } t_res_item;

    // Operation at a given step of a command's sequence.
    function automatic t_op seq_op(input logic [1:0] kind, input logic [3:0] step);
        t_op op;
        op = OP_STOP;
        case (kind)
            FUNC_WRITE_READBACK: begin
                case (step)
                    4'd0:    op = OP_START;
                    4'd1:    op = OP_ADDR_W;
                    4'd2:    op = OP_REG;
                    4'd3:    op = OP_VAL;
                    4'd4:    op = OP_STOP;
                    4'd5:    op = OP_START;
                    4'd6:    op = OP_ADDR_W;
                    4'd7:    op = OP_REG;
                    4'd8:    op = OP_START;
                    4'd9:    op = OP_ADDR_R;
                    4'd10:   op = OP_RD_NACK;
                    default: op = OP_STOP;
                endcase
            end
            FUNC_READ_REG: begin
                case (step)
                    4'd0:    op = OP_START;
                    4'd1:    op = OP_ADDR_W;
                    4'd2:    op = OP_REG;
                    4'd3:    op = OP_START;
                    4'd4:    op = OP_ADDR_R;
                    4'd5:    op = OP_RD_NACK;
                    default: op = OP_STOP;
                endcase
            end
            FUNC_READ_MEAS: begin
                case (step)
                    4'd0:    op = OP_START;
                    4'd1:    op = OP_ADDR_W;
                    4'd2:    op = OP_REG;
                    4'd3:    op = OP_START;
                    4'd4:    op = OP_ADDR_R;
                    4'd5:    op = OP_RD_ACK;
                    4'd6:    op = OP_RD_NACK;
                    default: op = OP_STOP;
                endcase
            end
            default: op = OP_START;
        endcase
        return op;
    endfunction

    // Index of the last step of a command's sequence.
    function automatic logic [3:0] seq_last(input logic [1:0] kind);
        logic [3:0] last;
        case (kind)
            FUNC_WRITE_READBACK: last = 4'd11;
            FUNC_READ_REG:       last = 4'd6;
            FUNC_READ_MEAS:      last = 4'd7;
            default:             last = 4'd0;
        endcase
        return last;
    endfunction

endpackage

FILE: hdl/i2cram_if.sv
// ----------------------------------------------------------------------------
// I2C register access master - channel interfaces
// Valid/ready channels for commands, results and the address register.
// ----------------------------------------------------------------------------

// Command channel: one bus delay period per word.
interface i2cram_cmd_if;
    import i2cram_pkg::*;
    logic      valid;
    logic      ready;
    t_cmd_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Result channel: line drive levels and status per word.
interface i2cram_res_if;
    import i2cram_pkg::*;
    logic      valid;
    logic      ready;
    t_res_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Configuration channel: the seven-bit target address.
interface i2cram_cfg_if;
    import i2cram_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [DEV_ADDR_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/i2c_register_access_master_core.sv
// ----------------------------------------------------------------------------
// I2C register access master - core
// Open-drain master sequencer that runs register write/readback, register
// read and 16-bit measurement transactions, one bus delay period per word.
//
//  channel | dir | payload
//  --------+-----+-----------------------------------------------------------
//  i_cmd   | in  | func, reg_addr, write_data, sda_in
//  o_res   | out | scl/sda pull low, busy, done, read_result, nack_seen
//  i_cfg   | in  | device_address (always ready)
//
//  Every command word yields exactly one result word: it passes the
//  input register, then the sequencer step that loads the result
//  register. A new word is taken every cycle while the output does not
//  stall; the input register holds a word back only when the result
//  register is held by a stalled output.
//  Synchronous active-low reset releases both lines and idles the
//  sequencer; the target address returns to 116.
// ----------------------------------------------------------------------------
module i2c_register_access_master_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    i2cram_cmd_if.sink          i_cmd,
    i2cram_res_if.source        o_res,
    i2cram_cfg_if.sink          i_cfg
);
    import i2cram_pkg::*;

    // Pipeline registers.
    logic      r_in_valid;
    t_cmd_item r_in;
    logic      r_out_valid;
    t_res_item r_out;
    logic      step_en;

    // Sequencer state.
    logic [DEV_ADDR_W-1:0] r_dev_addr;
    logic [1:0]  r_kind,      n_kind;
    logic [3:0]  r_seq,       n_seq;
    logic [1:0]  r_phase,     n_phase;
    logic [3:0]  r_bit,       n_bit;
    logic [7:0]  r_shift,     n_shift;
    logic [7:0]  r_held_reg,  n_held_reg;
    logic [7:0]  r_held_val,  n_held_val;
    logic [15:0] r_collected, n_collected;
    logic        r_nack,      n_nack;
    logic        r_scl_low,   n_scl_low;
    logic        r_sda_low,   n_sda_low;
    t_res_item   n_out;

    // Handshakes: the input register drains whenever the result register
    // is free or being taken.
    assign step_en     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || step_en;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;
    assign i_cfg.ready = 1'b1;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
        if (i_cmd.valid && i_cmd.ready) begin
            r_in <= i_cmd.data;
        end
    end

    // Target address register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= DEV_ADDR_W'(116);
        end else if (i_cfg.valid) begin
            r_dev_addr <= i_cfg.data;
        end
    end

    // One bus delay period of the sequencer.
    always_comb begin
        logic       start_cmd;
        logic       op_done;
        logic       busy;
        logic       done;
        t_op        op;
        logic [7:0] tx_byte;

        start_cmd = (r_kind == FUNC_TICK) && (r_in.func != FUNC_TICK);
        op_done   = 1'b0;
        busy      = 1'b0;
        done      = 1'b0;

        n_kind      = start_cmd ? r_in.func       : r_kind;
        n_held_reg  = start_cmd ? r_in.reg_addr   : r_held_reg;
        n_held_val  = start_cmd ? r_in.write_data : r_held_val;
        n_nack      = start_cmd ? 1'b0            : r_nack;
        n_collected = start_cmd ? 16'd0           : r_collected;
        n_seq       = start_cmd ? 4'd0            : r_seq;
        n_phase     = start_cmd ? PH_SET          : r_phase;
        n_bit       = start_cmd ? 4'd0            : r_bit;
        n_shift     = r_shift;
        n_scl_low   = r_scl_low;
        n_sda_low   = r_sda_low;

        op = seq_op(n_kind, n_seq);

        // Byte sent by a write operation.
        case (op)
            OP_ADDR_W: tx_byte = {r_dev_addr, 1'b0};
            OP_ADDR_R: tx_byte = {r_dev_addr, 1'b1};
            OP_REG:    tx_byte = n_held_reg;
            default:   tx_byte = n_held_val;
        endcase

        if (n_kind != FUNC_TICK) begin
            busy = 1'b1;

            // Line levels for this period.
            case (op)
                OP_START: begin
                    if (n_phase == PH_SET) begin
                        n_sda_low = 1'b0;
                        n_scl_low = 1'b0;
                    end else if (n_phase == PH_HIGH) begin
                        n_sda_low = 1'b1;
                    end else begin
                        n_scl_low = 1'b1;
                    end
                end
                OP_STOP: begin
                    if (n_phase == PH_SET) begin
                        n_sda_low = 1'b1;
                    end else if (n_phase == PH_HIGH) begin
                        n_scl_low = 1'b0;
                    end else begin
                        n_sda_low = 1'b0;
                    end
                end
                OP_RD_ACK, OP_RD_NACK: begin
                    if (n_bit < ACK_SLOT) begin
                        if (n_phase == PH_SET) begin
                            if (n_bit == 4'd0) begin
                                n_shift = 8'd0;
                            end
                            n_sda_low = 1'b0;
                        end else if (n_phase == PH_HIGH) begin
                            n_scl_low = 1'b0;
                            n_shift   = {n_shift[6:0], r_in.sda_in};
                        end else begin
                            n_scl_low = 1'b1;
                        end
                    end else begin
                        if (n_phase == PH_SET) begin
                            // The second measurement byte lands in the high half.
                            if (n_kind == FUNC_READ_MEAS && op == OP_RD_NACK) begin
                                n_collected[15:8] = n_shift;
                            end else begin
                                n_collected[7:0] = n_shift;
                            end
                            n_sda_low = (op == OP_RD_ACK);
                        end else if (n_phase == PH_HIGH) begin
                            n_scl_low = 1'b0;
                        end else begin
                            n_scl_low = 1'b1;
                        end
                    end
                end
                default: begin
                    if (n_bit < ACK_SLOT) begin
                        if (n_phase == PH_SET) begin
                            if (n_bit == 4'd0) begin
                                n_shift = tx_byte;
                            end
                            n_sda_low = !n_shift[7];
                        end else if (n_phase == PH_HIGH) begin
                            n_scl_low = 1'b0;
                        end else begin
                            n_shift   = {n_shift[6:0], 1'b0};
                            n_scl_low = 1'b1;
                        end
                    end else begin
                        if (n_phase == PH_SET) begin
                            n_sda_low = 1'b0;
                        end else if (n_phase == PH_HIGH) begin
                            n_scl_low = 1'b0;
                            if (r_in.sda_in) begin
                                n_nack = 1'b1;
                            end
                        end else begin
                            n_scl_low = 1'b1;
                        end
                    end
                end
            endcase

            // Advance phase, bit slot and sequence step.
            if (n_phase == PH_LOW) begin
                n_phase = PH_SET;
                if (op == OP_START || op == OP_STOP) begin
                    op_done = 1'b1;
                end else if (n_bit == ACK_SLOT) begin
                    n_bit   = 4'd0;
                    op_done = 1'b1;
                end else begin
                    n_bit = n_bit + 4'd1;
                end
            end else begin
                n_phase = n_phase + 2'd1;
            end

            if (op_done) begin
                if (n_seq == seq_last(n_kind)) begin
                    n_kind = FUNC_TICK;
                    n_seq  = 4'd0;
                    done   = 1'b1;
                end else begin
                    n_seq = n_seq + 4'd1;
                end
            end
        end

        n_out.scl_pull_low = n_scl_low;
        n_out.sda_pull_low = n_sda_low;
        n_out.busy_res     = busy;
        n_out.done_res     = done;
        n_out.read_result  = n_collected;
        n_out.nack_seen    = n_nack;
    end

    // Sequencer state, advanced once per processed word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= FUNC_TICK;
            r_seq       <= 4'd0;
            r_phase     <= PH_SET;
            r_bit       <= 4'd0;
            r_shift     <= 8'd0;
            r_held_reg  <= 8'd0;
            r_held_val  <= 8'd0;
            r_collected <= 16'd0;
            r_nack      <= 1'b0;
            r_scl_low   <= 1'b0;
            r_sda_low   <= 1'b0;
        end else if (step_en) begin
            r_kind      <= n_kind;
            r_seq       <= n_seq;
            r_phase     <= n_phase;
            r_bit       <= n_bit;
            r_shift     <= n_shift;
            r_held_reg  <= n_held_reg;
            r_held_val  <= n_held_val;
            r_collected <= n_collected;
            r_nack      <= n_nack;
            r_scl_low   <= n_scl_low;
            r_sda_low   <= n_sda_low;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_en) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (step_en) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: hdl/i2cram_checker.sv
// ----------------------------------------------------------------------------
// I2C register access master - port checker
// Watches the ports of the master core over time; attached by bind.
// ----------------------------------------------------------------------------
`include "i2c_register_access_master_core_assert.svh"

module i2cram_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    i2cram_cmd_if.sink    i_cmd,
    i2cram_res_if.source  o_res,
    i2cram_cfg_if.sink    i_cfg
);
    import i2cram_pkg::*;

    logic cmd_take;
    logic res_stall;

    assign cmd_take  = i_cmd.valid && i_cmd.ready;
    assign res_stall = o_res.valid && !o_res.ready;

    // No result word may appear right after reset.
    `I2CRAM_CHECK_ALWAYS(a_no_res_after_rst, !i_rst_n |=> !o_res.valid, "result after reset")

    // Every accepted word has a result on offer once it has passed the input and result registers.
    `I2CRAM_CHECK(a_res_follows_cmd, cmd_take |-> ##2 o_res.valid, "result missing")

    // The final period of a transaction is busy and leaves both lines released.
    `I2CRAM_CHECK(a_done_released, o_res.valid && o_res.data.done_res |-> o_res.data.busy_res && !o_res.data.scl_pull_low && !o_res.data.sda_pull_low, "bad done period")

    // A stalled result word holds steady.
    `I2CRAM_CHECK(a_res_hold, res_stall |=> o_res.valid && $stable(o_res.data), "result changed under stall")

    // The address register never refuses a write.
    `I2CRAM_CHECK(a_cfg_ready, i_cfg.ready, "config not ready")

endmodule

bind i2c_register_access_master_core i2cram_checker u_i2cram_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_cmd   (i_cmd),
    .o_res   (o_res),
    .i_cfg   (i_cfg)
);

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// I2C register access master - testbench
// Drives bus delay periods into the master core over the command channel and
// runs a cycle-exact model of the sequencer next to it. Every result word is
// checked field by field against the model: line drive levels, busy, done,
// read data and the sticky NACK flag. Directed transactions cover each
// command, field extremes, the reset address and commands issued while busy.
// A long output stall follows, then a random phase with random idling on both
// channels and address changes between transactions.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cram_pkg::*;

    logic i_clk;
    logic i_rst_n;

    i2cram_cmd_if cmd_bus ();
    i2cram_res_if res_bus ();
    i2cram_cfg_if cfg_bus ();

    i2c_register_access_master_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    // Bus master model state.
    logic [6:0]  m_dev_addr;
    logic [1:0]  m_kind;
    logic [3:0]  m_step;
    logic [1:0]  m_phase;
    logic [3:0]  m_bit;
    logic [7:0]  m_shift;
    logic [7:0]  m_reg;
    logic [7:0]  m_val;
    logic [15:0] m_rdata;
    logic        m_nack;
    logic        m_scl_low;
    logic        m_sda_low;

    // Result words predicted for accepted command words, oldest first.
    t_res_item   pending_bus_results[$];

    int unsigned error_count;
    int unsigned periods_sent;
    int unsigned done_count;
    int unsigned nack_results;
    int unsigned addr_writes;
    int unsigned txn_count[4];

    // Idling controls for the sender and the ready driver.
    int unsigned tx_gap_pct;
    int unsigned rx_stall_pct;
    int unsigned rx_hold_cycles;

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard limit on the run time.
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Gap length: mostly short, now and then long.
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Bus operation at a given step of a transaction.
    function automatic t_op txn_op(input logic [1:0] kind, input logic [3:0] idx);
        t_op wr [12];
        t_op rr [7];
        t_op ms [8];
        wr = '{OP_START, OP_ADDR_W, OP_REG, OP_VAL, OP_STOP, OP_START,
               OP_ADDR_W, OP_REG, OP_START, OP_ADDR_R, OP_RD_NACK, OP_STOP};
        rr = '{OP_START, OP_ADDR_W, OP_REG, OP_START, OP_ADDR_R, OP_RD_NACK, OP_STOP};
        ms = '{OP_START, OP_ADDR_W, OP_REG, OP_START, OP_ADDR_R, OP_RD_ACK,
               OP_RD_NACK, OP_STOP};
        case (kind)
            FUNC_WRITE_READBACK: return (idx < 12) ? wr[idx] : OP_STOP;
            FUNC_READ_REG:       return (idx < 7) ? rr[idx] : OP_STOP;
            FUNC_READ_MEAS:      return (idx < 8) ? ms[idx] : OP_STOP;
            default:             return OP_START;
        endcase
    endfunction

    // Number of operations in a transaction.
    function automatic logic [3:0] txn_len(input logic [1:0] kind);
        case (kind)
            FUNC_WRITE_READBACK: return 4'd12;
            FUNC_READ_REG:       return 4'd7;
            FUNC_READ_MEAS:      return 4'd8;
            default:             return 4'd1;
        endcase
    endfunction

    // Advance the master model by one delay period and return its result word.
    function automatic t_res_item step_bus_master(input t_cmd_item it);
        t_res_item r;
        t_op       op;
        logic      busy;
        logic      done;
        logic      op_end;
        busy = 1'b0;
        done = 1'b0;
        op_end = 1'b0;

        // A command is only taken while idle.
        if (m_kind == FUNC_TICK && it.func != FUNC_TICK) begin
            m_kind  = it.func;
            m_reg   = it.reg_addr;
            m_val   = it.write_data;
            m_nack  = 1'b0;
            m_rdata = '0;
            m_step  = '0;
            m_phase = PH_SET;
            m_bit   = '0;
        end

        if (m_kind != FUNC_TICK) begin
            busy = 1'b1;
            op = txn_op(m_kind, m_step);
            case (op)
                OP_START: begin
                    if (m_phase == PH_SET) begin
                        m_sda_low = 1'b0;
                        m_scl_low = 1'b0;
                    end else if (m_phase == PH_HIGH) begin
                        m_sda_low = 1'b1;
                    end else begin
                        m_scl_low = 1'b1;
                    end
                end
                OP_STOP: begin
                    if (m_phase == PH_SET) m_sda_low = 1'b1;
                    else if (m_phase == PH_HIGH) m_scl_low = 1'b0;
                    else m_sda_low = 1'b0;
                end
                OP_RD_ACK, OP_RD_NACK: begin
                    if (m_bit < ACK_SLOT) begin
                        if (m_phase == PH_SET) begin
                            if (m_bit == 0) m_shift = '0;
                            m_sda_low = 1'b0;
                        end else if (m_phase == PH_HIGH) begin
                            m_scl_low = 1'b0;
                            m_shift = {m_shift[6:0], it.sda_in};
                        end else begin
                            m_scl_low = 1'b1;
                        end
                    end else begin
                        if (m_phase == PH_SET) begin
                            // The second measurement byte lands in the high half.
                            if (m_kind == FUNC_READ_MEAS && op == OP_RD_NACK)
                                m_rdata[15:8] = m_shift;
                            else
                                m_rdata[7:0] = m_shift;
                            m_sda_low = (op == OP_RD_ACK);
                        end else if (m_phase == PH_HIGH) begin
                            m_scl_low = 1'b0;
                        end else begin
                            m_scl_low = 1'b1;
                        end
                    end
                end
                default: begin
                    if (m_bit < ACK_SLOT) begin
                        if (m_phase == PH_SET) begin
                            if (m_bit == 0) begin
                                if (op == OP_ADDR_W) m_shift = {m_dev_addr, 1'b0};
                                else if (op == OP_ADDR_R) m_shift = {m_dev_addr, 1'b1};
                                else if (op == OP_REG) m_shift = m_reg;
                                else m_shift = m_val;
                            end
                            m_sda_low = ~m_shift[7];
                        end else if (m_phase == PH_HIGH) begin
                            m_scl_low = 1'b0;
                        end else begin
                            m_shift = {m_shift[6:0], 1'b0};
                            m_scl_low = 1'b1;
                        end
                    end else begin
                        if (m_phase == PH_SET) begin
                            m_sda_low = 1'b0;
                        end else if (m_phase == PH_HIGH) begin
                            m_scl_low = 1'b0;
                            if (it.sda_in) m_nack = 1'b1;
                        end else begin
                            m_scl_low = 1'b1;
                        end
                    end
                end
            endcase

            // Move on one period, then one slot, then one operation.
            if (m_phase == PH_LOW) begin
                m_phase = PH_SET;
                if (op == OP_START || op == OP_STOP) begin
                    op_end = 1'b1;
                end else if (m_bit == ACK_SLOT) begin
                    m_bit = '0;
                    op_end = 1'b1;
                end else begin
                    m_bit = m_bit + 4'd1;
                end
            end else begin
                m_phase = m_phase + 2'd1;
            end
            if (op_end) begin
                if (m_step == txn_len(m_kind) - 4'd1) begin
                    m_kind = FUNC_TICK;
                    m_step = '0;
                    done = 1'b1;
                end else begin
                    m_step = m_step + 4'd1;
                end
            end
        end

        r.scl_pull_low = m_scl_low;
        r.sda_pull_low = m_sda_low;
        r.busy_res     = busy;
        r.done_res     = done;
        r.read_result  = m_rdata;
        r.nack_seen    = m_nack;
        return r;
    endfunction

    // SDA seen from a target that acknowledges every written byte when asked to.
    function automatic logic target_sda(input logic acks);
        t_op op;
        if (acks && m_kind != FUNC_TICK) begin
            op = txn_op(m_kind, m_step);
            if (op != OP_START && op != OP_STOP && op != OP_RD_ACK && op != OP_RD_NACK
                && m_bit == ACK_SLOT)
                return 1'b0;
        end
        return 1'(($urandom_range(0, 1)));
    endfunction

    // Send one command word and record the result it must produce.
    task automatic send_period(input t_cmd_item it);
        int unsigned g;
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            g = gap_len();
            cmd_bus.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        cmd_bus.valid <= 1'b1;
        cmd_bus.data  <= it;
        do @(posedge i_clk); while (!cmd_bus.ready);
        pending_bus_results.push_back(step_bus_master(it));
        periods_sent++;
    endtask

    // Hold the sender until every predicted word has come back.
    task automatic wait_for_results();
        if (cmd_bus.valid) cmd_bus.valid <= 1'b0;
        while (pending_bus_results.size() != 0) @(posedge i_clk);
    endtask

    // Write the target address while the master is idle.
    task automatic set_device_address(input logic [6:0] addr);
        wait_for_results();
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= addr;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        m_dev_addr = addr;
        addr_writes++;
    endtask

    // Ticks with no command while idle.
    task automatic idle_ticks(input int unsigned n);
        t_cmd_item it;
        repeat (n) begin
            it.func       = FUNC_TICK;
            it.reg_addr   = 8'($urandom);
            it.write_data = 8'($urandom);
            it.sda_in     = 1'($urandom);
            send_period(it);
        end
    endtask

    // One whole transaction: the command word, then periods until it is done.
    // With noise, the periods carry random commands that must be ignored.
    task automatic run_transaction(input t_func func, input logic [7:0] reg_addr,
                                   input logic [7:0] wdata, input logic acks,
                                   input logic noise);
        t_cmd_item it;
        it.func       = func;
        it.reg_addr   = reg_addr;
        it.write_data = wdata;
        it.sda_in     = 1'($urandom);
        txn_count[func]++;
        send_period(it);
        while (m_kind != FUNC_TICK) begin
            it.func       = noise ? 2'($urandom) : FUNC_TICK;
            it.reg_addr   = 8'($urandom);
            it.write_data = 8'($urandom);
            it.sda_in     = target_sda(acks);
            send_period(it);
        end
    endtask

    // Result ready: random stalls, plus a long hold-off on request.
    initial begin : res_ready_driver
        int unsigned n;
        res_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_cycles != 0) begin
                n = rx_hold_cycles;
                rx_hold_cycles = 0;
                res_bus.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
                n = gap_len();
                res_bus.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    function automatic void report_field(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
        if (want !== got) begin
            error_count++;
            if (error_count <= 30)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // Compare each accepted result word with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_res_item want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (pending_bus_results.size() == 0) begin
                error_count++;
                if (error_count <= 30)
                    $display("%0t: unexpected result word, expected none, actual %0h",
                             $time, res_bus.data);
            end else begin
                want = pending_bus_results.pop_front();
                report_field("scl_pull_low", 16'(want.scl_pull_low),
                             16'(res_bus.data.scl_pull_low));
                report_field("sda_pull_low", 16'(want.sda_pull_low),
                             16'(res_bus.data.sda_pull_low));
                report_field("busy_res", 16'(want.busy_res), 16'(res_bus.data.busy_res));
                report_field("done_res", 16'(want.done_res), 16'(res_bus.data.done_res));
                report_field("read_result", want.read_result, res_bus.data.read_result);
                report_field("nack_seen", 16'(want.nack_seen), 16'(res_bus.data.nack_seen));
                if (want.done_res) begin
                    done_count++;
                    if (want.nack_seen) nack_results++;
                end
            end
        end
    end

    // First transaction runs on the reset address with a well-behaved target.
    task automatic test_reset_address();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        run_transaction(FUNC_READ_REG, 8'h00, 8'hFF, 1'b1, 1'b0);
    endtask

    // Write with readback at both address extremes and both data extremes.
    task automatic test_write_readback();
        tx_gap_pct   = 25;
        rx_stall_pct = 25;
        set_device_address(7'h7F);
        run_transaction(FUNC_WRITE_READBACK, 8'hFF, 8'h00, 1'b1, 1'b0);
        set_device_address(7'h00);
        run_transaction(FUNC_WRITE_READBACK, 8'h00, 8'hFF, 1'b0, 1'b0);
    endtask

    // Register read and measurements, one acknowledged and two not.
    task automatic test_reads();
        set_device_address(7'h55);
        run_transaction(FUNC_READ_MEAS, 8'h80, 8'h7F, 1'b1, 1'b0);
        run_transaction(FUNC_READ_REG, 8'h7F, 8'h80, 1'b0, 1'b0);
        run_transaction(FUNC_READ_MEAS, 8'hA5, 8'h5A, 1'b0, 1'b0);
    endtask

    // Idle ticks hold the lines; commands offered while busy are ignored.
    task automatic test_idle_and_busy();
        idle_ticks(8);
        run_transaction(FUNC_WRITE_READBACK, 8'h5A, 8'hA5, 1'b0, 1'b1);
        idle_ticks(3);
        run_transaction(FUNC_READ_MEAS, 8'h3C, 8'hC3, 1'b1, 1'b1);
    endtask

    // Long output stall with the sender still offering words, then a
    // command right after the previous one finishes.
    task automatic test_output_backpressure();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        wait_for_results();
        rx_hold_cycles = 150;
        run_transaction(FUNC_READ_MEAS, 8'hF0, 8'h0F, 1'b0, 1'b1);
        run_transaction(FUNC_READ_REG, 8'h0F, 8'hF0, 1'b1, 1'b0);
        wait_for_results();
    endtask

    // Random transactions with random content, idling and address changes.
    task automatic test_random_traffic();
        int unsigned first;
        int unsigned n_txn;
        logic [6:0]  addr;
        t_func       func;
        first = periods_sent;
        n_txn = 0;
        while (periods_sent - first < 150) begin
            if (n_txn % 3 == 2) begin
                case ($urandom_range(0, 3))
                    0:       addr = 7'h00;
                    1:       addr = 7'h7F;
                    2:       addr = 7'd116;
                    default: addr = 7'($urandom);
                endcase
                set_device_address(addr);
                // Choose at random between steady streaming and heavy idling.
                if ($urandom_range(0, 2) == 0) begin
                    tx_gap_pct   = 0;
                    rx_stall_pct = 0;
                end else begin
                    tx_gap_pct   = $urandom_range(10, 50);
                    rx_stall_pct = $urandom_range(10, 50);
                end
            end
            if ($urandom_range(0, 7) == 0) wait_for_results();
            idle_ticks($urandom_range(0, 4));
            func = t_func'($urandom_range(1, 3));
            run_transaction(func, 8'($urandom), 8'($urandom), 1'($urandom),
                            $urandom_range(0, 3) != 0);
            n_txn++;
        end
    endtask

    // Main sequence.
    initial begin
        error_count    = 0;
        periods_sent   = 0;
        done_count     = 0;
        nack_results   = 0;
        addr_writes    = 0;
        txn_count      = '{default: 0};
        tx_gap_pct     = 0;
        rx_stall_pct   = 0;
        rx_hold_cycles = 0;

        m_dev_addr = 7'd116;
        m_kind     = FUNC_TICK;
        m_step     = '0;
        m_phase    = PH_SET;
        m_bit      = '0;
        m_shift    = '0;
        m_reg      = '0;
        m_val      = '0;
        m_rdata    = '0;
        m_nack     = 1'b0;
        m_scl_low  = 1'b0;
        m_sda_low  = 1'b0;

        i_rst_n       <= 1'b0;
        cmd_bus.valid <= 1'b0;
        cmd_bus.data  <= '0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_address();
        test_write_readback();
        test_reads();
        test_idle_and_busy();
        test_output_backpressure();
        test_random_traffic();

        wait_for_results();
        repeat (10) @(posedge i_clk);
        if (pending_bus_results.size() != 0) begin
            error_count++;
            $display("%0t: %0d result words never arrived", $time,
                     pending_bus_results.size());
        end

        $display("Covered %0d bus periods and %0d finished transactions (%0d with a NACK).",
                 periods_sent, done_count, nack_results);
        $display("Commands: %0d write/readback, %0d register reads, %0d measurements;",
                 txn_count[FUNC_WRITE_READBACK], txn_count[FUNC_READ_REG],
                 txn_count[FUNC_READ_MEAS]);
        $display("Address register writes: %0d.", addr_writes);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
